[rtl/assert_macros.svh]
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

[rtl/wsfp_pkg.sv]
package wsfp_pkg;

	typedef enum logic [1:0] {
		KIND_DATA       = 2'd0,
		KIND_HEADER     = 2'd1,
		KIND_BAD_OPCODE = 2'd2,
		KIND_UNMASKED   = 2'd3
	} kind_t;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	localparam int TDATA_W = 80;

	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'ha;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// One queued result: the back end does the unmask XOR and formatting.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  raw;
		logic [7:0]  key;
		logic        fin;
		logic [3:0]  opcode;
		logic [63:0] len;
		logic        last;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic opcode_ok(input logic [3:0] op);
		return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN) ||
			(op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
	endfunction

endpackage

[rtl/websocket_frame_unmask_parser.sv]
// WebSocket client-to-server frame parser with payload unmasking.
// Input stream s_axis carries one raw frame byte per item in tdata[7:0].
// Output stream m_axis carries one result per item: tuser gives the kind
// (payload byte, frame header, bad opcode error, unmasked frame error) and
// tlast marks the final result of a frame, which is the header when the
// payload is empty and always an error result.
// Header and mask-key bytes produce no result, except an error result on a bad
// header byte; the header result follows the last mask-key byte, and each
// payload byte comes out XORed with the key. Throughput is one byte per cycle in
// and one result per cycle out while the receiver keeps tready high. The edge that
// accepts a byte writes its result into the four-entry result queue, and the output
// register loads it once it reaches the head of the queue and the register is free.
// When the receiver holds tready low the queue fills, and s_axis_tready
// drops once it holds four results; parsing resumes as soon as it drains.
// Reset clears the parser to wait for the first byte of a new frame and
// empties the queue and the output register.
`include "assert_macros.svh"

module websocket_frame_unmask_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // [7:0] rx_byte
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [7:0] data_byte, [8] fin, [12:9] frame_opcode, [76:13] payload_length, [79:77] zero
	output logic [wsfp_pkg::TDATA_W-1:0]      m_axis_tdata,
	output logic [1:0]                        m_axis_tuser,  // [1:0] kind
	output logic                              m_axis_tlast
);

	logic                  fire;
	logic                  push;
	logic                  pop;
	wsfp_pkg::item_t       push_item;
	wsfp_pkg::item_t       head_item;
	wsfp_pkg::q_status_t   q_status;
	logic                  out_hdr;
	logic                  out_err;
	logic                  out_len_zero;

	assign s_axis_tready = !q_status.full;
	assign fire = s_axis_tvalid && s_axis_tready;

	wsfp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.rx_byte (s_axis_tdata),
		.push    (push),
		.item    (push_item)
	);

	wsfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.status    (q_status)
	);

	wsfp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_item     (head_item),
		.q_status      (q_status),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	assign out_hdr = m_axis_tvalid && (m_axis_tuser == wsfp_pkg::KIND_HEADER);
	assign out_err = m_axis_tvalid && ((m_axis_tuser == wsfp_pkg::KIND_BAD_OPCODE) ||
		(m_axis_tuser == wsfp_pkg::KIND_UNMASKED));
	assign out_len_zero = (m_axis_tdata[76:13] == 64'd0);

	`ASSERT_IMPLIES(a_hdr_last_iff_empty, clk, arst_n, out_hdr, m_axis_tlast == out_len_zero)
	`ASSERT_IMPLIES(a_error_is_last, clk, arst_n, out_err, m_axis_tlast)
	`ASSERT_IMPLIES(a_len_only_in_header, clk, arst_n, m_axis_tvalid && !out_hdr, out_len_zero)
	`ASSERT_IMPLIES(a_no_push_when_full, clk, arst_n, q_status.full, !push)

endmodule

[rtl/wsfp_front.sv]
module wsfp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          rx_byte,
	output logic                push,
	output wsfp_pkg::item_t     item
);

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_MASK    = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	phase_t      phase_q;
	logic [2:0]  ext_cnt_q;
	logic [63:0] rem_q;
	logic [31:0] key_q;
	logic [1:0]  idx_q;
	logic        fin_q;
	logic [3:0]  opc_q;

	logic [63:0] rem_dec;
	logic [7:0]  key_byte;

	assign rem_dec = rem_q - 64'd1;

	always_comb begin
		case (idx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		push = 1'b0;
		item = '0;
		item.fin = fin_q;
		item.opcode = opc_q;
		case (phase_q)
			PH_HDR1: begin
				if (!rx_byte[7]) begin
					push = fire;
					item.kind = wsfp_pkg::KIND_UNMASKED;
					item.last = 1'b1;
				end
			end
			PH_EXTLEN: begin
				push = 1'b0;
			end
			PH_MASK: begin
				if (idx_q == 2'd3) begin
					push = fire;
					item.kind = wsfp_pkg::KIND_HEADER;
					item.len = rem_q;
					item.last = (rem_q == 64'd0);
				end
			end
			PH_PAYLOAD: begin
				push = fire;
				item.kind = wsfp_pkg::KIND_DATA;
				item.raw = rx_byte;
				item.key = key_byte;
				item.last = (rem_dec == 64'd0);
			end
			default: begin
				if (!wsfp_pkg::opcode_ok(rx_byte[3:0])) begin
					push = fire;
					item.kind = wsfp_pkg::KIND_BAD_OPCODE;
					item.fin = rx_byte[7];
					item.opcode = rx_byte[3:0];
					item.last = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			ext_cnt_q <= 3'd0;
			rem_q <= 64'd0;
			key_q <= 32'd0;
			idx_q <= 2'd0;
			fin_q <= 1'b0;
			opc_q <= 4'd0;
		end else if (fire) begin
			case (phase_q)
				PH_HDR1: begin
					if (!rx_byte[7]) begin
						phase_q <= PH_HDR0;
					end else begin
						key_q <= 32'd0;
						idx_q <= 2'd0;
						if (rx_byte[6:0] < wsfp_pkg::LEN_EXT16) begin
							rem_q <= {57'd0, rx_byte[6:0]};
							phase_q <= PH_MASK;
						end else begin
							rem_q <= 64'd0;
							ext_cnt_q <= (rx_byte[6:0] == wsfp_pkg::LEN_EXT64) ? 3'd7 : 3'd1;
							phase_q <= PH_EXTLEN;
						end
					end
				end
				PH_EXTLEN: begin
					rem_q <= {rem_q[55:0], rx_byte};
					if (ext_cnt_q == 3'd0) begin
						phase_q <= PH_MASK;
					end else begin
						ext_cnt_q <= ext_cnt_q - 3'd1;
					end
				end
				PH_MASK: begin
					key_q <= {key_q[23:0], rx_byte};
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd3) begin
						phase_q <= (rem_q == 64'd0) ? PH_HDR0 : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					idx_q <= idx_q + 2'd1;
					rem_q <= rem_dec;
					if (rem_dec == 64'd0) begin
						phase_q <= PH_HDR0;
					end
				end
				default: begin
					if (wsfp_pkg::opcode_ok(rx_byte[3:0])) begin
						fin_q <= rx_byte[7];
						opc_q <= rx_byte[3:0];
						phase_q <= PH_HDR1;
					end else begin
						phase_q <= PH_HDR0;
					end
				end
			endcase
		end
	end

endmodule

[rtl/wsfp_queue.sv]
module wsfp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  wsfp_pkg::item_t       push_item,
	input  logic                  pop,
	output wsfp_pkg::item_t       head_item,
	output wsfp_pkg::q_status_t   status
);

	wsfp_pkg::item_t             entry_q [wsfp_pkg::QDEPTH];
	logic [wsfp_pkg::QAW-1:0]    wr_ptr_q;
	logic [wsfp_pkg::QAW-1:0]    rd_ptr_q;
	logic [wsfp_pkg::QAW:0]      count_q;
	logic                        do_push;
	logic                        do_pop;

	assign status.full = (count_q == (wsfp_pkg::QAW+1)'(wsfp_pkg::QDEPTH));
	assign status.empty = (count_q == '0);
	assign do_push = push && !status.full;
	assign do_pop = pop && !status.empty;
	assign head_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/wsfp_back.sv]
module wsfp_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  wsfp_pkg::item_t                   head_item,
	input  wsfp_pkg::q_status_t               q_status,
	output logic                              pop,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [wsfp_pkg::TDATA_W-1:0]      m_axis_tdata,
	output logic [1:0]                        m_axis_tuser,
	output logic                              m_axis_tlast
);

	logic       valid_q;
	logic [7:0] data_byte;

	// Only payload items carry a data byte; every other kind shows zero.
	assign data_byte = (head_item.kind == wsfp_pkg::KIND_DATA) ?
		(head_item.raw ^ head_item.key) : 8'h00;
	assign pop = !q_status.empty && (!valid_q || m_axis_tready);
	assign m_axis_tvalid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			m_axis_tdata <= {3'd0, head_item.len, head_item.opcode, head_item.fin, data_byte};
			m_axis_tuser <= head_item.kind;
			m_axis_tlast <= head_item.last;
		end
	end

endmodule

[sim/websocket_frame_unmask_parser_tb.sv]
`timescale 1ns / 1ps

module websocket_frame_unmask_parser_tb;
	import wsfp_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_BYTES = 1850;

	typedef enum logic [2:0] {
		AWAIT_HDR0,
		AWAIT_HDR1,
		READ_EXT_LEN,
		READ_KEY,
		READ_PAYLOAD
	} parse_phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic        fin;
		logic [3:0]  opcode;
		logic [63:0] length;
		logic        last;
	} frame_result_t;

	// An item with hold set is not offered until every expected result has arrived.
	typedef struct packed {
		logic       hold;
		logic [7:0] value;
	} raw_byte_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_valid = 1'b0;
	logic                s_ready;
	logic [7:0]          s_data = 8'h00;
	logic                m_valid;
	logic                m_ready = 1'b0;
	logic [TDATA_W-1:0]  m_data;
	logic [1:0]          m_user;
	logic                m_last;

	raw_byte_t     wire_bytes[$];
	raw_byte_t     next_byte;
	frame_result_t results_due[$];
	frame_result_t want;

	// Software copy of the parser state.
	parse_phase_t phase;
	logic [2:0]   ext_left;
	logic [63:0]  bytes_left;
	logic [31:0]  key_word;
	logic [1:0]   key_pos;
	logic         cur_fin;
	logic [3:0]   cur_op;

	int  n_errors = 0;
	int  n_in = 0;
	int  n_kind[4] = '{0, 0, 0, 0};
	int  stall = 0;
	logic quiet;

	assign quiet = (n_in >= 500) && (n_in < 900);

	websocket_frame_unmask_parser DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tuser  (m_user),
		.m_axis_tlast  (m_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic is_known_op(input logic [3:0] op);
		case (op)
			OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [3:0] pick_op(input logic known);
		logic [3:0] op;
		op = 4'($urandom);
		while (is_known_op(op) != known)
			op = 4'($urandom);
		return op;
	endfunction

	task automatic expect_result(input kind_t kind, input logic [7:0] data, input logic fin,
			input logic [3:0] op, input logic [63:0] length, input logic last);
		frame_result_t r;
		r.kind = kind;
		r.data = data;
		r.fin = fin;
		r.opcode = op;
		r.length = length;
		r.last = last;
		results_due.push_back(r);
	endtask

	// Advances the parser copy by one received byte and queues any result it causes.
	task automatic unmask_and_parse(input logic [7:0] b);
		logic       key_done;
		logic [7:0] key_byte;
		case (phase)
			AWAIT_HDR1: begin
				if (!b[7]) begin
					phase = AWAIT_HDR0;
					expect_result(KIND_UNMASKED, 8'h00, cur_fin, cur_op, 64'd0, 1'b1);
				end else begin
					key_word = 32'd0;
					key_pos = 2'd0;
					if (b[6:0] < LEN_EXT16) begin
						bytes_left = {57'd0, b[6:0]};
						phase = READ_KEY;
					end else begin
						bytes_left = 64'd0;
						ext_left = (b[6:0] == LEN_EXT16) ? 3'd1 : 3'd7;
						phase = READ_EXT_LEN;
					end
				end
			end
			READ_EXT_LEN: begin
				bytes_left = {bytes_left[55:0], b};
				if (ext_left == 3'd0)
					phase = READ_KEY;
				else
					ext_left = ext_left - 3'd1;
			end
			READ_KEY: begin
				key_done = (key_pos == 2'd3);
				key_word = {key_word[23:0], b};
				key_pos = key_pos + 2'd1;
				if (key_done) begin
					phase = (bytes_left == 64'd0) ? AWAIT_HDR0 : READ_PAYLOAD;
					expect_result(KIND_HEADER, 8'h00, cur_fin, cur_op, bytes_left,
						bytes_left == 64'd0);
				end
			end
			READ_PAYLOAD: begin
				key_byte = key_word[8 * (3 - key_pos) +: 8];
				key_pos = key_pos + 2'd1;
				bytes_left = bytes_left - 64'd1;
				if (bytes_left == 64'd0)
					phase = AWAIT_HDR0;
				expect_result(KIND_DATA, b ^ key_byte, cur_fin, cur_op, 64'd0,
					bytes_left == 64'd0);
			end
			default: begin
				phase = AWAIT_HDR0;
				if (!is_known_op(b[3:0])) begin
					expect_result(KIND_BAD_OPCODE, 8'h00, b[7], b[3:0], 64'd0, 1'b1);
				end else begin
					cur_fin = b[7];
					cur_op = b[3:0];
					phase = AWAIT_HDR1;
				end
			end
		endcase
	endtask

	task automatic queue_byte(input logic [7:0] value, input logic hold);
		raw_byte_t rb;
		rb.hold = hold;
		rb.value = value;
		wire_bytes.push_back(rb);
	endtask

	// len_code 0 sends the length in the second byte, 1 as 16 bits, 2 as 64 bits.
	task automatic queue_frame(input logic fin, input logic [3:0] op, input int len_code,
			input logic [63:0] length, input logic [31:0] key, input int n_payload,
			input logic hold);
		queue_byte({fin, 3'($urandom), op}, hold);
		case (len_code)
			0: queue_byte({1'b1, length[6:0]}, 1'b0);
			1: begin
				queue_byte({1'b1, LEN_EXT16}, 1'b0);
				queue_byte(length[15:8], 1'b0);
				queue_byte(length[7:0], 1'b0);
			end
			default: begin
				queue_byte({1'b1, LEN_EXT64}, 1'b0);
				for (int i = 7; i >= 0; i--)
					queue_byte(length[8 * i +: 8], 1'b0);
			end
		endcase
		for (int i = 3; i >= 0; i--)
			queue_byte(key[8 * i +: 8], 1'b0);
		for (int i = 0; i < n_payload; i++)
			queue_byte(8'($urandom), 1'b0);
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, got_v);
			n_errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_valid <= 1'b0;
			s_data <= 8'h00;
		end else begin
			if (s_valid && s_ready) begin
				unmask_and_parse(s_data);
				n_in++;
			end
			if (!s_valid || s_ready) begin
				if (wire_bytes.size() != 0 && (quiet || $urandom_range(0, 99) >= 27) &&
						!(wire_bytes[0].hold && results_due.size() != 0)) begin
					next_byte = wire_bytes.pop_front();
					s_valid <= 1'b1;
					s_data <= next_byte.value;
				end else begin
					s_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_ready <= 1'b0;
		end else begin
			if (m_valid && m_ready) begin
				n_kind[m_user]++;
				if (results_due.size() == 0) begin
					$error("result with nothing expected: kind %0d tdata %0h", m_user, m_data);
					n_errors++;
				end else begin
					want = results_due.pop_front();
					check_field("kind", want.kind, m_user);
					check_field("data_byte", want.data, m_data[7:0]);
					check_field("fin", want.fin, m_data[8]);
					check_field("frame_opcode", want.opcode, m_data[12:9]);
					check_field("payload_length", want.length, m_data[76:13]);
					check_field("tdata padding", 64'd0, m_data[TDATA_W-1:77]);
					check_field("last", want.last, m_last);
				end
			end
			m_ready <= quiet || ($urandom_range(0, 99) >= 27);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
			stall <= 0;
		end else if (stall == STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stall <= stall + 1;
		end
	end

	initial begin
		int   pick;
		int   len_code;
		logic [63:0] length;
		logic first_frame;

		phase = AWAIT_HDR0;
		ext_left = 3'd0;
		bytes_left = 64'd0;
		key_word = 32'd0;
		key_pos = 2'd0;
		cur_fin = 1'b0;
		cur_op = 4'd0;

		// Directed: both error kinds, an empty control frame and a short text frame.
		queue_byte({1'b1, 3'b000, 4'h3}, 1'b0);
		queue_byte(8'h7f, 1'b0);
		queue_byte({1'b1, 3'b000, OP_TEXT}, 1'b0);
		queue_byte(8'h05, 1'b0);
		queue_byte({1'b0, 3'b111, OP_CONT}, 1'b0);
		queue_byte(8'h7f, 1'b0);
		queue_frame(1'b1, OP_CLOSE, 0, 64'd0, 32'h0000_0000, 0, 1'b0);
		queue_frame(1'b0, OP_TEXT, 0, 64'd5, 32'hff00_ff00, 5, 1'b0);

		first_frame = 1'b1;
		while (wire_bytes.size() < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				queue_byte({1'($urandom), 3'($urandom), pick_op(1'b0)}, 1'b0);
			end else if (pick < 13) begin
				queue_byte({1'($urandom), 3'($urandom), pick_op(1'b1)}, 1'b0);
				queue_byte({1'b0, 7'($urandom)}, 1'b0);
			end else begin
				len_code = $urandom_range(0, 9);
				if (len_code <= 6) begin
					len_code = 0;
					length = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 125)
						: $urandom_range(0, 12);
				end else if (len_code <= 8) begin
					len_code = 1;
					length = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1500)
						: $urandom_range(0, 40);
				end else begin
					len_code = 2;
					length = $urandom_range(0, 40);
				end
				queue_frame(1'($urandom), pick_op(1'b1), len_code, length, $urandom,
					int'(length), first_frame || ($urandom_range(0, 29) == 0));
				first_frame = 1'b0;
			end
		end

		// The largest 64-bit length never completes, so it closes the run.
		queue_frame(1'b1, OP_BIN, 2, 64'hffff_ffff_ffff_ffff, $urandom, 24, 1'b1);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (wire_bytes.size() != 0 || s_valid)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d frame bytes; saw %0d headers and %0d unmasked payload bytes,",
			n_in, n_kind[KIND_HEADER], n_kind[KIND_DATA]);
		$display("plus %0d bad-opcode and %0d unmasked-frame errors.",
			n_kind[KIND_BAD_OPCODE], n_kind[KIND_UNMASKED]);
		if (n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/wsfp_pkg.sv
rtl/wsfp_front.sv
rtl/wsfp_queue.sv
rtl/wsfp_back.sv
rtl/websocket_frame_unmask_parser.sv
sim/websocket_frame_unmask_parser_tb.sv
